[rtl/hpt_pkg.sv]
// Shared types and constants for the homogeneous point transform.
package hpt_pkg;

  // Width of one coordinate and of one matrix element.
  localparam int COORD_W = 32;
  // Exact column sum: three 64-bit products plus the translation term.
  localparam int SUM_W = 66;
  // Quotient bits produced by the divider; more than that always saturates.
  localparam int QUO_BITS = 33;
  // Divider pipeline depth: operand preparation, one stage per quotient bit, result.
  localparam int DIV_LAT = QUO_BITS + 2;

  // Matrix register indexes.
  localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [2:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [2:0] REG_ROW3_COLS23 = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic signed [COORD_W-1:0] tz;
    logic                      w_zero;
    logic                      saturated;
  } result_t;

endpackage

[rtl/homogeneous_point_transform_top.sv]
// Top level of the homogeneous point transform pipeline.
//
// A point item (px, py, pz) enters on point/point_valid and is taken at an
// edge where point_stall is low. It is multiplied as (x, y, z, 1) by the 4x4
// matrix in the eight configuration registers, and x', y', z' are divided by w.
// The result item leaves on result/result_valid and is taken at an edge where
// result_stall is low.
// Throughput is one item per cycle while result_stall does not hold the pipeline. Registers in order:
// input register, product stage, two adder stages, then 35 divider stages (operand setup, one
// stage per quotient bit of the 33-bit restoring divider, result) and the
// output register.
// When the receiver stalls a waiting result, the whole pipeline holds and
// point_stall is raised; nothing is dropped or repeated.
// The configuration channel takes a write every cycle (cfg_ready is high);
// write only while the pipeline is empty.
// Reset empties the pipeline and loads the identity matrix.
module homogeneous_point_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_stall,
  input  hpt_pkg::point_t  point,
  output logic             result_valid,
  input  logic             result_stall,
  output hpt_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  localparam int CW = hpt_pkg::COORD_W;
  localparam int PW = 2 * CW;
  localparam int SW = hpt_pkg::SUM_W;
  localparam int CUT_W = SW - FRAC_BITS;
  localparam int LAT = hpt_pkg::DIV_LAT;
  localparam logic [63:0] ONE_LO = 64'(1) << FRAC_BITS;
  localparam logic [63:0] ONE_HI = 64'(1) << (FRAC_BITS + 32);

  logic en;
  assign en          = !(result_valid && result_stall);
  assign point_stall = !en;
  assign cfg_ready   = 1'b1;

  // Matrix registers, identity after reset.
  logic [63:0] mat [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      mat[hpt_pkg::REG_ROW0_COLS01] <= ONE_LO;
      mat[hpt_pkg::REG_ROW0_COLS23] <= '0;
      mat[hpt_pkg::REG_ROW1_COLS01] <= ONE_HI;
      mat[hpt_pkg::REG_ROW1_COLS23] <= '0;
      mat[hpt_pkg::REG_ROW2_COLS01] <= '0;
      mat[hpt_pkg::REG_ROW2_COLS23] <= ONE_LO;
      mat[hpt_pkg::REG_ROW3_COLS01] <= '0;
      mat[hpt_pkg::REG_ROW3_COLS23] <= ONE_HI;
    end else if (cfg_valid) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  // Matrix element M[r][c] as a signed value.
  logic signed [CW-1:0] m [4][4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (c % 2 == 1) ? mat[r*2 + c/2][63:32] : mat[r*2 + c/2][31:0];
      end
    end
  end

  // Input register.
  logic                 vld1;
  logic signed [CW-1:0] v1 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else if (en) begin
      vld1 <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1[0] <= point.px;
      v1[1] <= point.py;
      v1[2] <= point.pz;
    end
  end

  // Products and translation terms.
  logic                 vld2;
  logic signed [PW-1:0] prod [3][4];
  logic signed [SW-1:0] bias [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld2 <= 1'b0;
    end else if (en) begin
      vld2 <= vld1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 3; r++) begin
          prod[r][c] <= PW'(v1[r]) * PW'(m[r][c]);
        end
        bias[c] <= {{(SW-CW-FRAC_BITS){m[3][c][CW-1]}}, m[3][c], {FRAC_BITS{1'b0}}};
      end
    end
  end

  // First adder level.
  logic                 vld3;
  logic signed [SW-1:0] s01 [4];
  logic signed [SW-1:0] s2b [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld3 <= 1'b0;
    end else if (en) begin
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        s01[c] <= {{(SW-PW){prod[0][c][PW-1]}}, prod[0][c]}
                + {{(SW-PW){prod[1][c][PW-1]}}, prod[1][c]};
        s2b[c] <= {{(SW-PW){prod[2][c][PW-1]}}, prod[2][c]} + bias[c];
      end
    end
  end

  // Final sum and cut to the fraction width.
  logic                    vld4;
  logic signed [CUT_W-1:0] col [4];
  logic signed [SW-1:0]    total [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      total[c] = s01[c] + s2b[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
    end else if (en) begin
      vld4 <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        col[c] <= total[c][SW-1:FRAC_BITS];
      end
    end
  end

  // Perspective divide, one divider per coordinate.
  logic signed [CW-1:0] quo [3];
  logic                 sat [3];

  for (genvar c = 0; c < 3; c++) begin : g_div
    hpt_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (col[c]),
      .den (col[3]),
      .quo (quo[c]),
      .sat (sat[c])
    );
  end

  // Valid and zero-w flag travel alongside the dividers.
  logic vld_d [LAT];
  logic wz_d  [LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) begin
        vld_d[i] <= 1'b0;
      end
    end else if (en) begin
      vld_d[0] <= vld4;
      for (int i = 1; i < LAT; i++) begin
        vld_d[i] <= vld_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wz_d[0] <= (col[3] == '0);
      for (int i = 1; i < LAT; i++) begin
        wz_d[i] <= wz_d[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= vld_d[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (wz_d[LAT-1]) begin
        result.tx        <= '0;
        result.ty        <= '0;
        result.tz        <= '0;
        result.w_zero    <= 1'b1;
        result.saturated <= 1'b0;
      end else begin
        result.tx        <= quo[0];
        result.ty        <= quo[1];
        result.tz        <= quo[2];
        result.w_zero    <= 1'b0;
        result.saturated <= sat[0] | sat[1] | sat[2];
      end
    end
  end

endmodule

[rtl/hpt_div.sv]
// Pipelined signed divider: (num << FRAC_BITS) / den, truncated and saturated to 32 bits.
module hpt_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic signed [hpt_pkg::SUM_W-FRAC_BITS-1:0]    num,
  input  logic signed [hpt_pkg::SUM_W-FRAC_BITS-1:0]    den,
  output logic signed [hpt_pkg::COORD_W-1:0]            quo,
  output logic                                          sat
);

  localparam int SW = hpt_pkg::SUM_W - FRAC_BITS;
  localparam int NW = hpt_pkg::SUM_W;
  localparam int QB = hpt_pkg::QUO_BITS;
  localparam int RW = SW + QB;
  localparam logic [QB-1:0] LIM_POS = QB'(32'h7FFF_FFFF);
  localparam logic [QB-1:0] LIM_NEG = QB'(33'h0_8000_0000);

  logic [RW-1:0] rem [QB+1];
  logic [SW-1:0] dd  [QB+1];
  logic [QB-1:0] q   [QB+1];
  logic          neg [QB+1];
  logic          ovf [QB+1];

  // Operand magnitudes and the early overflow check.
  logic [SW-1:0] nmag;
  logic [SW-1:0] dmag;
  logic [NW-1:0] nsh;
  logic          ovf_in;

  always_comb begin
    nmag   = num[SW-1] ? SW'(-num) : SW'(num);
    dmag   = den[SW-1] ? SW'(-den) : SW'(den);
    nsh    = {nmag, {FRAC_BITS{1'b0}}};
    ovf_in = {{(RW-NW){1'b0}}, nsh} >= {dmag, {QB{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {{(RW-NW){1'b0}}, nsh};
      dd[0]  <= dmag;
      q[0]   <= '0;
      neg[0] <= num[SW-1] ^ den[SW-1];
      ovf[0] <= ovf_in;
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = {dd[k], {QB{1'b0}}} >> (k + 1);
    assign ge = rem[k] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - sh : rem[k];
        q[k+1]   <= {q[k][QB-2:0], ge};
        dd[k+1]  <= dd[k];
        neg[k+1] <= neg[k];
        ovf[k+1] <= ovf[k];
      end
    end
  end

  // Saturate the magnitude and restore the sign.
  logic [QB-1:0] limit;
  logic [QB-1:0] mag;
  logic [QB-1:0] mag_n;
  logic          clamp;

  always_comb begin
    limit = neg[QB] ? LIM_NEG : LIM_POS;
    clamp = ovf[QB] || (q[QB] > limit);
    mag   = clamp ? limit : q[QB];
    mag_n = (~mag) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg[QB] ? mag_n[hpt_pkg::COORD_W-1:0] : mag[hpt_pkg::COORD_W-1:0];
      sat <= clamp;
    end
  end

endmodule
